>>> rtl/sacc_pkg.sv
// Shared types and constants for the set-associative write-through cache.
// No dependencies.
package sacc_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FILL  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_READ_DATA = 2'd0,
        KIND_FETCH     = 2'd1,
        KIND_WRITE     = 2'd2
    } kind_t;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [15:0] LFSR_ONE  = 16'h0001;

    typedef struct packed {
        op_t         op;
        logic [31:0] address;
        logic [1:0]  size;
        logic [31:0] data;
    } item_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_TAG,
        S_RD_CHK,
        S_FETCH_OUT,
        S_FILL_WAIT,
        S_BYTE_TAG,
        S_BYTE_CHK,
        S_BYTE_DATA,
        S_RESP,
        S_WT_OUT
    } state_t;

endpackage

>>> rtl/sacc_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module sacc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/sacc_front.sv
// Front end: accepts beats, normalizes size and data, queues them.
// Depends on sacc_pkg.
module sacc_front import sacc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [31:0] address,
    input  logic [1:0]  size_code,
    input  logic [31:0] write_data,
    input  logic [31:0] fill_word,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);
    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      item_in;
    logic       push;

    always_comb
    begin
        item_in.op      = op_t'(op);
        item_in.address = address;
        item_in.size    = (size_code == SIZE_HALF || size_code == SIZE_BYTE) ? size_code
                                                                             : SIZE_WORD;
        case (op_t'(op))
            OP_FILL:  item_in.data = fill_word;
            default:
            begin
                case (item_in.size)
                    SIZE_BYTE: item_in.data = {24'd0, write_data[7:0]};
                    SIZE_HALF: item_in.data = {16'd0, write_data[15:0]};
                    default:   item_in.data = write_data;
                endcase
            end
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

>>> rtl/sacc_back.sv
// Back end: tag lookup, byte walk, miss fetch, fill and result register.
// Depends on sacc_pkg and sacc_ram.
module sacc_back import sacc_pkg::*; #(
    parameter int LINE_OFFSET_BITS = 6,
    parameter int WAY_BITS         = 3,
    parameter int SET_BITS         = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    input  logic        cfg_write_enable,
    input  logic [15:0] cfg_write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [31:0] out_address,
    output logic [31:0] out_data,
    output logic [1:0]  out_size_code
);
    localparam int NWAYS      = 1 << WAY_BITS;
    localparam int NSETS      = 1 << SET_BITS;
    localparam int WORD_BITS  = LINE_OFFSET_BITS - 2;
    localparam int TAG_W      = 32 - LINE_OFFSET_BITS - SET_BITS;
    localparam int ROW_W      = NWAYS * (TAG_W + 1);
    localparam int DAW        = SET_BITS + WAY_BITS + WORD_BITS;
    localparam logic [31:0] LINE_BYTES = 32'(1) << LINE_OFFSET_BITS;

    state_t               state_reg, state_next;
    logic [SET_BITS-1:0]  clr_idx_reg, clr_idx_next;
    logic [31:0]          a_reg, a_next;
    logic [1:0]           size_reg, size_next;
    logic [31:0]          wdata_reg, wdata_next;
    logic                 is_write_reg, is_write_next;
    logic                 line_sel_reg, line_sel_next;
    logic [1:0]           byte_idx_reg, byte_idx_next;
    logic [31:0]          acc_reg, acc_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [WAY_BITS-1:0]  hit_way_reg, hit_way_next;
    logic [WAY_BITS-1:0]  victim_reg, victim_next;
    logic [WORD_BITS-1:0] fill_cnt_reg, fill_cnt_next;
    logic [15:0]          lfsr_reg, lfsr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           kind_reg, kind_next;
    logic [31:0]          out_addr_reg, out_addr_next;
    logic [31:0]          out_data_reg, out_data_next;
    logic [1:0]           out_size_reg, out_size_next;

    logic                 tag_we;
    logic [SET_BITS-1:0]  tag_waddr, tag_raddr;
    logic [ROW_W-1:0]     tag_wdata, tag_rdata, row_upd;
    logic                 data_we;
    logic [DAW-1:0]       data_waddr, data_raddr;
    logic [31:0]          data_wdata, data_rdata, word_mod;

    logic [31:0]          line_addr, byte_addr, lk_addr;
    logic                 lk_hit;
    logic [WAY_BITS-1:0]  lk_way, first_free;
    logic                 any_free;
    logic [1:0]           last_idx;
    logic                 crosses;
    logic [15:0]          lfsr_step, seed;
    logic                 can_out;

    sacc_ram #(.WIDTH(ROW_W), .DEPTH(NSETS)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    sacc_ram #(.WIDTH(32), .DEPTH(1 << DAW)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign out_address   = out_addr_reg;
    assign out_data      = out_data_reg;
    assign out_size_code = out_size_reg;

    // lookup, victim choice and datapath helpers
    always_comb
    begin
        line_addr = line_sel_reg ? a_reg + LINE_BYTES : a_reg;
        byte_addr = a_reg + {30'd0, byte_idx_reg};
        lk_addr   = (state_reg == S_RD_CHK) ? line_addr : byte_addr;
        last_idx  = (size_reg == SIZE_WORD) ? 2'd3 : size_reg;
        crosses   = ({1'b0, a_reg[LINE_OFFSET_BITS-1:0]} + (LINE_OFFSET_BITS + 1)'(last_idx)
                     + (LINE_OFFSET_BITS + 1)'(1)) > LINE_BYTES[LINE_OFFSET_BITS:0];

        lk_hit = 1'b0;
        lk_way = '0;
        any_free = 1'b0;
        first_free = '0;
        for (int w = NWAYS - 1; w >= 0; w--)
        begin
            if (tag_rdata[NWAYS*TAG_W + w]
                && tag_rdata[w*TAG_W +: TAG_W] == lk_addr[31:LINE_OFFSET_BITS+SET_BITS])
            begin
                lk_hit = 1'b1;
                lk_way = WAY_BITS'(w);
            end
            if (!tag_rdata[NWAYS*TAG_W + w])
            begin
                any_free = 1'b1;
                first_free = WAY_BITS'(w);
            end
        end

        lfsr_step = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : 16'd0);
        seed      = (cfg_write_data == 16'd0) ? LFSR_ONE : cfg_write_data;

        row_upd = row_reg;
        row_upd[victim_reg*TAG_W +: TAG_W] = line_addr[31:LINE_OFFSET_BITS+SET_BITS];
        row_upd[NWAYS*TAG_W + int'(victim_reg)] = 1'b1;

        word_mod = data_rdata;
        word_mod[byte_addr[1:0]*8 +: 8] = wdata_reg[byte_idx_reg*8 +: 8];

        can_out = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        a_next         = a_reg;
        size_next      = size_reg;
        wdata_next     = wdata_reg;
        is_write_next  = is_write_reg;
        line_sel_next  = line_sel_reg;
        byte_idx_next  = byte_idx_reg;
        acc_next       = acc_reg;
        row_next       = row_reg;
        hit_way_next   = hit_way_reg;
        victim_next    = victim_reg;
        fill_cnt_next  = fill_cnt_reg;
        lfsr_next      = lfsr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        out_addr_next  = out_addr_reg;
        out_data_next  = out_data_reg;
        out_size_next  = out_size_reg;
        q_pop          = 1'b0;

        tag_we     = 1'b0;
        tag_waddr  = line_addr[LINE_OFFSET_BITS +: SET_BITS];
        tag_wdata  = row_upd;
        tag_raddr  = byte_addr[LINE_OFFSET_BITS +: SET_BITS];
        data_we    = 1'b0;
        data_waddr = {byte_addr[LINE_OFFSET_BITS +: SET_BITS], hit_way_reg,
                      byte_addr[LINE_OFFSET_BITS-1:2]};
        data_wdata = word_mod;
        data_raddr = {byte_addr[LINE_OFFSET_BITS +: SET_BITS], lk_way,
                      byte_addr[LINE_OFFSET_BITS-1:2]};

        case (state_reg)
            S_CLEAR:
            begin
                tag_we    = 1'b1;
                tag_waddr = clr_idx_reg;
                tag_wdata = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (&clr_idx_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    a_next        = q_item.address;
                    size_next     = q_item.size;
                    wdata_next    = q_item.data;
                    line_sel_next = 1'b0;
                    byte_idx_next = 2'd0;
                    acc_next      = '0;
                    case (q_item.op)
                        OP_READ:
                        begin
                            is_write_next = 1'b0;
                            state_next    = S_RD_TAG;
                        end
                        OP_WRITE:
                        begin
                            is_write_next = 1'b1;
                            state_next    = S_BYTE_TAG;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_TAG:
            begin
                tag_raddr  = line_addr[LINE_OFFSET_BITS +: SET_BITS];
                state_next = S_RD_CHK;
            end
            S_RD_CHK:
            begin
                if (lk_hit)
                begin
                    if (!line_sel_reg && crosses)
                    begin
                        line_sel_next = 1'b1;
                        state_next    = S_RD_TAG;
                    end
                    else
                    begin
                        byte_idx_next = 2'd0;
                        acc_next      = '0;
                        state_next    = S_BYTE_TAG;
                    end
                end
                else
                begin
                    row_next = tag_rdata;
                    if (any_free)
                    begin
                        victim_next = first_free;
                    end
                    else
                    begin
                        lfsr_next   = lfsr_step;
                        victim_next = lfsr_step[WAY_BITS-1:0];
                    end
                    fill_cnt_next = '0;
                    state_next    = S_FETCH_OUT;
                end
            end
            S_FETCH_OUT:
            begin
                if (can_out)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_FETCH;
                    out_addr_next  = {line_addr[31:LINE_OFFSET_BITS],
                                      LINE_OFFSET_BITS'(0)};
                    out_data_next  = '0;
                    out_size_next  = SIZE_BYTE;
                    state_next     = S_FILL_WAIT;
                end
            end
            S_FILL_WAIT:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.op == OP_FILL)
                    begin
                        data_we    = 1'b1;
                        data_waddr = {line_addr[LINE_OFFSET_BITS +: SET_BITS], victim_reg,
                                      fill_cnt_reg};
                        data_wdata = q_item.data;
                        fill_cnt_next = fill_cnt_reg + 1'b1;
                        if (&fill_cnt_reg)
                        begin
                            tag_we        = 1'b1;
                            line_sel_next = 1'b0;
                            state_next    = S_RD_TAG;
                        end
                    end
                end
            end
            S_BYTE_TAG:
            begin
                state_next = S_BYTE_CHK;
            end
            S_BYTE_CHK:
            begin
                hit_way_next = lk_way;
                if (lk_hit)
                begin
                    state_next = S_BYTE_DATA;
                end
                else if (byte_idx_reg == last_idx)
                begin
                    state_next = is_write_reg ? S_WT_OUT : S_RESP;
                end
                else
                begin
                    byte_idx_next = byte_idx_reg + 1'b1;
                    state_next    = S_BYTE_TAG;
                end
            end
            S_BYTE_DATA:
            begin
                if (is_write_reg)
                begin
                    data_we = 1'b1;
                end
                else
                begin
                    acc_next[byte_idx_reg*8 +: 8] = data_rdata[byte_addr[1:0]*8 +: 8];
                end
                if (byte_idx_reg == last_idx)
                begin
                    state_next = is_write_reg ? S_WT_OUT : S_RESP;
                end
                else
                begin
                    byte_idx_next = byte_idx_reg + 1'b1;
                    state_next    = S_BYTE_TAG;
                end
            end
            S_RESP:
            begin
                if (can_out)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_READ_DATA;
                    out_addr_next  = a_reg;
                    out_data_next  = acc_reg;
                    out_size_next  = SIZE_BYTE;
                    state_next     = S_IDLE;
                end
            end
            S_WT_OUT:
            begin
                if (can_out)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_WRITE;
                    out_addr_next  = a_reg;
                    out_data_next  = wdata_reg;
                    out_size_next  = size_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_write_enable)
        begin
            lfsr_next = seed;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        size_reg     <= size_next;
        wdata_reg    <= wdata_next;
        is_write_reg <= is_write_next;
        byte_idx_reg <= byte_idx_next;
        acc_reg      <= acc_next;
        row_reg      <= row_next;
        hit_way_reg  <= hit_way_next;
        kind_reg     <= kind_next;
        out_addr_reg <= out_addr_next;
        out_data_reg <= out_data_next;
        out_size_reg <= out_size_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            line_sel_reg  <= 1'b0;
            victim_reg    <= '0;
            fill_cnt_reg  <= '0;
            lfsr_reg      <= LFSR_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            line_sel_reg  <= line_sel_next;
            victim_reg    <= victim_next;
            fill_cnt_reg  <= fill_cnt_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != 16'd0)
        else $error("replacement lfsr reached zero");

    a_fill_count_home: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_cnt_reg != '0) |-> (state_reg == S_FILL_WAIT))
        else $error("fill count left nonzero outside fill");

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !q_pop)
        else $error("queue popped during tag clear");

    a_no_load_over_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("held result dropped");

endmodule

>>> rtl/set_assoc_write_through_cache_unit.sv
// Top level of the set-associative write-through cache.
// Depends on sacc_pkg, sacc_front, sacc_back (and sacc_ram through it).
//
// 8-way, 128-set write-through cache with 64-byte lines and random
// replacement. After reset the tag store is cleared one set per cycle
// before the back end starts on the first beat; the queue still takes
// up to two beats meanwhile. Beats enter a two-entry queue; the back
// end handles one at a time and walks the access one byte per tag and
// data RAM read: a read first looks up the tag of each line it touches
// (a second line when it crosses one), then walks its bytes; a write
// walks its bytes and skips the data write for a byte that misses, and
// a read miss adds the fetch request, the fill words and a repeated tag
// lookup.
module set_assoc_write_through_cache_unit import sacc_pkg::*; #(
    parameter int LINE_OFFSET_BITS = 6,
    parameter int WAY_BITS         = 3,
    parameter int SET_BITS         = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [31:0] address,
    input  logic [1:0]  size_code,
    input  logic [31:0] write_data,
    input  logic [31:0] fill_word,
    input  logic        cfg_write_enable,
    input  logic [15:0] cfg_write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [31:0] out_address,
    output logic [31:0] out_data,
    output logic [1:0]  out_size_code
);
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    sacc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .address    (address),
        .size_code  (size_code),
        .write_data (write_data),
        .fill_word  (fill_word),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    sacc_back #(
        .LINE_OFFSET_BITS (LINE_OFFSET_BITS),
        .WAY_BITS         (WAY_BITS),
        .SET_BITS         (SET_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .out_address      (out_address),
        .out_data         (out_data),
        .out_size_code    (out_size_code)
    );
endmodule

>>> tb/sv/tb_set_assoc_write_through_cache_unit.sv
`timescale 1ns / 1ps
// Testbench for set_assoc_write_through_cache_unit: random and directed reads,
// writes and line fills checked beat by beat against a built-in cache predictor.
// Depends on sacc_pkg and the cache RTL.
module tb_set_assoc_write_through_cache_unit import sacc_pkg::*;;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] data;
        logic [1:0]  size;
    } resp_t;

    class cache_scoreboard;
        bit [31:0] line_data[int];
        bit [18:0] tags[1024];
        bit        valid[1024];
        bit [15:0] lfsr;
        bit [31:0] rd_addr;
        bit [1:0]  rd_size;
        bit        rd_second;
        bit        filling;
        int        fill_cnt;
        int        victim;
        resp_t     awaited[$];
        int        errors;
        int        n_read;
        int        n_fetch;
        int        n_write;

        function new();
            lfsr = LFSR_ONE;
        endfunction

        function void set_seed(bit [15:0] v);
            lfsr = (v == 0) ? LFSR_ONE : v;
        endfunction

        function int span(bit [1:0] code);
            return code >= SIZE_WORD ? 4 : (code == SIZE_HALF ? 2 : 1);
        endfunction

        function int find_way(bit [31:0] a);
            for (int w = 0; w < 8; w++)
                if (valid[a[12:6] * 8 + w] && tags[a[12:6] * 8 + w] == a[31:13])
                    return w;
            return -1;
        endfunction

        function void push(logic [1:0] k, bit [31:0] a, bit [31:0] d, bit [1:0] sc);
            resp_t r;
            r.kind = k;
            r.addr = a;
            r.data = d;
            r.size = sc;
            awaited.push_back(r);
        endfunction

        function void start_fetch(bit [31:0] a, bit second);
            int w;
            w = 0;
            while (w < 8 && valid[a[12:6] * 8 + w])
                w++;
            if (w == 8) begin
                lfsr = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 16'h0);
                w = lfsr[2:0];
            end
            victim = w;
            fill_cnt = 0;
            filling = 1;
            rd_second = second;
            push(KIND_FETCH, {a[31:6], 6'b0}, 0, SIZE_BYTE);
        endfunction

        function void advance_read();
            int len;
            int w;
            bit [31:0] b;
            bit [31:0] acc;
            bit [31:0] wd;
            len = span(rd_size);
            acc = 0;
            if (find_way(rd_addr) < 0) begin
                start_fetch(rd_addr, 0);
                return;
            end
            if (int'(rd_addr[5:0]) + len > 64 && find_way(rd_addr + 64) < 0) begin
                start_fetch(rd_addr + 64, 1);
                return;
            end
            for (int i = 0; i < len; i++) begin
                b = rd_addr + i;
                w = find_way(b);
                wd = line_data[(b[12:6] * 8 + w) * 16 + b[5:2]];
                acc |= ((wd >> (b[1:0] * 8)) & 32'hff) << (i * 8);
            end
            filling = 0;
            push(KIND_READ_DATA, rd_addr, acc, SIZE_BYTE);
        endfunction

        // returns 1 when the beat is not ignored by the block
        function bit note_input(logic [1:0] op, bit [31:0] a, bit [1:0] sc,
                                bit [31:0] wdat, bit [31:0] fw);
            bit [31:0] la;
            bit [31:0] b;
            bit [31:0] mask;
            int idx;
            int w;
            int len;
            if (filling) begin
                if (op != OP_FILL)
                    return 0;
                la = rd_addr + (rd_second ? 32'd64 : 32'd0);
                idx = la[12:6] * 8 + victim;
                line_data[idx * 16 + fill_cnt] = fw;
                fill_cnt = (fill_cnt + 1) % 16;
                if (fill_cnt == 0) begin
                    tags[idx] = la[31:13];
                    valid[idx] = 1;
                    advance_read();
                end
                return 1;
            end
            if (op == OP_READ) begin
                rd_addr = a;
                rd_size = sc;
                advance_read();
                return 1;
            end
            if (op == OP_WRITE) begin
                len = span(sc);
                mask = (len == 4) ? 32'hffff_ffff : ((32'd1 << (len * 8)) - 1);
                for (int i = 0; i < len; i++) begin
                    b = a + i;
                    w = find_way(b);
                    if (w >= 0) begin
                        idx = (b[12:6] * 8 + w) * 16 + b[5:2];
                        line_data[idx][b[1:0] * 8 +: 8] = wdat[i * 8 +: 8];
                    end
                end
                push(KIND_WRITE, a, wdat & mask, sc >= SIZE_WORD ? SIZE_WORD : sc);
                return 1;
            end
            return 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [1:0] k, logic [31:0] a, logic [31:0] d, logic [1:0] sc);
            resp_t e;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected beat kind=%0d addr=%h", k, a));
                return;
            end
            e = awaited.pop_front();
            if (k !== e.kind)
                report($sformatf("kind %0d, want %0d", k, e.kind));
            if (a !== e.addr)
                report($sformatf("address %h, want %h", a, e.addr));
            if (d !== e.data)
                report($sformatf("data %h, want %h (addr %h)", d, e.data, e.addr));
            if (sc !== e.size)
                report($sformatf("size %0d, want %0d", sc, e.size));
            case (e.kind)
                KIND_READ_DATA: n_read++;
                KIND_FETCH:     n_fetch++;
                default:        n_write++;
            endcase
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [31:0] address;
    logic [1:0]  size_code;
    logic [31:0] write_data;
    logic [31:0] fill_word;
    logic        cfg_write_enable;
    logic [15:0] cfg_write_data;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [31:0] out_address;
    logic [31:0] out_data;
    logic [1:0]  out_size_code;

    cache_scoreboard sb;
    int          send_idle;
    int          recv_stall;
    int          accepted;
    bit [18:0]   tag_pool[12];
    bit [6:0]    set_pool[4];

    set_assoc_write_through_cache_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .address          (address),
        .size_code        (size_code),
        .write_data       (write_data),
        .fill_word        (fill_word),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .out_address      (out_address),
        .out_data         (out_data),
        .out_size_code    (out_size_code)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(kind, out_address, out_data, out_size_code);
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task send_beat(logic [1:0] o, bit [31:0] a, bit [1:0] sc, bit [31:0] wd, bit [31:0] fw);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid   <= 1;
        op         <= o;
        address    <= a;
        size_code  <= sc;
        write_data <= wd;
        fill_word  <= fw;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (sb.note_input(o, a, sc, wd, fw))
            accepted++;
    endtask

    task finish_fill();
        while (sb.filling)
            send_beat(OP_FILL, $urandom, 2'($urandom), $urandom, $urandom);
    endtask

    task drain();
        in_valid <= 0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task write_seed(bit [15:0] v);
        cfg_write_enable <= 1;
        cfg_write_data   <= v;
        @(posedge clk);
        cfg_write_enable <= 0;
        sb.set_seed(v);
    endtask

    function bit [31:0] pick_address();
        bit [31:0] a;
        a = {tag_pool[$urandom_range(11)], set_pool[$urandom_range(3)], 6'b0};
        a[5:0] = ($urandom_range(3) == 0) ? 6'($urandom_range(60, 63)) : 6'($urandom);
        if ($urandom_range(15) == 0)
            a = $urandom;
        return a;
    endfunction

    task random_beat();
        int r;
        r = $urandom_range(99);
        if (sb.filling)
        begin
            if (r < 90)
                send_beat(OP_FILL, $urandom, 2'($urandom), $urandom, $urandom);
            else
                send_beat(2'($urandom_range(1) ? OP_NONE : r[0]), pick_address(),
                          2'($urandom), $urandom, $urandom);
        end
        else if (r < 45)
            send_beat(OP_READ, pick_address(), 2'($urandom), $urandom, $urandom);
        else if (r < 85)
            send_beat(OP_WRITE, pick_address(), 2'($urandom), $urandom, $urandom);
        else
            send_beat($urandom_range(1) ? OP_FILL : OP_NONE, $urandom, 2'($urandom),
                      $urandom, $urandom);
    endtask

    task run_phase(int idle_pct, int stall_pct, int count);
        int goal;
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        goal = accepted + count;
        while (accepted < goal || sb.filling)
        begin
            random_beat();
            if (accepted == goal - count / 2 && !sb.filling)
                drain();
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        rst_n            = 0;
        in_valid         = 0;
        op               = OP_NONE;
        address          = 0;
        size_code        = 0;
        write_data       = 0;
        fill_word        = 0;
        cfg_write_enable = 0;
        cfg_write_data   = 0;
        out_ready        = 0;
        send_idle        = 0;
        recv_stall       = 0;
        accepted         = 0;
        tag_pool[0] = 19'h0;
        tag_pool[1] = 19'h7ffff;
        for (int i = 2; i < 12; i++)
            tag_pool[i] = 19'($urandom);
        set_pool[0] = 0;
        set_pool[1] = 1;
        set_pool[2] = 7'h7f;
        set_pool[3] = 7'($urandom);
        repeat (3) @(posedge clk);
        rst_n <= 1;
        write_seed(16'hffff);

        // directed: misses, hits, wrapping cross, size three, ignored beats
        send_beat(OP_FILL, 0, 0, 0, 32'hffff_ffff);
        send_beat(OP_NONE, 0, 0, 0, 0);
        send_beat(OP_READ, 32'h0, SIZE_BYTE, 0, 0);
        send_beat(OP_WRITE, 32'h4, SIZE_HALF, 0, 0);
        finish_fill();
        send_beat(OP_READ, 32'h3f, SIZE_WORD, 0, 0);
        send_beat(OP_READ, 32'h10, SIZE_HALF, 0, 0);
        finish_fill();
        send_beat(OP_WRITE, 32'h3e, 2'd3, 32'hffff_ffff, 0);
        send_beat(OP_WRITE, 32'h0, SIZE_BYTE, 32'h0000_00a5, 0);
        send_beat(OP_READ, 32'h3e, SIZE_WORD, 0, 0);
        send_beat(OP_READ, 32'hffff_fffe, 2'd3, 0, 0);
        finish_fill();
        send_beat(OP_WRITE, 32'hffff_ffff, SIZE_WORD, 32'h1234_5678, 0);
        send_beat(OP_READ, 32'hffff_ffff, SIZE_HALF, 0, 0);
        send_beat(OP_WRITE, 32'hffff_ffff, SIZE_BYTE, 32'hffff_ffff, 0);
        finish_fill();
        drain();

        write_seed(16'h0000);
        run_phase(19, 49, 400);
        write_seed(16'h0001);
        run_phase(49, 19, 400);
        write_seed(16'($urandom_range(2, 65534)));
        run_phase(0, 0, 400);

        $display("covered %0d read responses, %0d line fetches, %0d write-throughs",
                 sb.n_read, sb.n_fetch, sb.n_write);
        $display("across four seed settings, %0d beats that produced work", accepted);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

>>> set_assoc_write_through_cache_unit.f
rtl/sacc_pkg.sv
rtl/sacc_ram.sv
rtl/sacc_front.sv
rtl/sacc_back.sv
rtl/set_assoc_write_through_cache_unit.sv
tb/sv/tb_set_assoc_write_through_cache_unit.sv
